// File: rtl/i2f_pkg.sv
// Shared constants and stage payload types for the int32 to float32 converter.
package i2f_pkg;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned FracBits  = 23;
  localparam int unsigned ExpBias   = 127;
  localparam int unsigned PosWidth  = 5;

  typedef struct packed {
    logic        sign;
    logic        zero;
    logic [31:0] mag;
  } mag_t;

  typedef struct packed {
    logic        sign;
    logic        zero;
    logic [4:0]  pos;
    logic [31:0] norm;
  } norm_t;
endpackage

// File: rtl/i2f_stage.sv
// One pipeline register stage with valid/ready flow control.
module i2f_stage #(
  parameter int unsigned Width = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [Width-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [Width-1:0] out_data
);
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= in_data;
    end
  end
endmodule

// File: rtl/i2f_norm.sv
// Leading-one search and left alignment of the magnitude.
module i2f_norm (
  input  i2f_pkg::mag_t  m,
  output i2f_pkg::norm_t n
);
  logic [4:0] pos;

  always_comb begin
    pos = '0;
    for (int i = 0; i < 32; i++) begin
      if (m.mag[i]) pos = 5'(i);
    end
  end

  assign n.sign = m.sign;
  assign n.zero = m.zero;
  assign n.pos  = pos;
  // leading one lands at bit 31
  assign n.norm = m.mag << (5'd31 - pos);
endmodule

// File: rtl/i2f_round.sv
// Round to nearest even and pack the single-precision word.
module i2f_round (
  input  i2f_pkg::norm_t n,
  output logic [31:0]    f
);
  logic [23:0] sig;
  logic        guard;
  logic        sticky;
  logic        up;
  logic [24:0] sum;
  logic [7:0]  expo;

  assign sig    = n.norm[31:8];
  assign guard  = n.norm[7];
  assign sticky = |n.norm[6:0];
  assign up     = guard && (sticky || sig[0]);
  assign sum    = {1'b0, sig} + 25'(up);
  assign expo   = 8'(n.pos) + 8'(i2f_pkg::ExpBias) + 8'(sum[24]);

  always_comb begin
    if (n.zero) f = '0;
    else f = {n.sign, expo, sum[24] ? sum[23:1] : sum[22:0]};
  end
endmodule

// File: rtl/int32_to_float32_convert_top.sv
// Throughput: one word per cycle; each of the three register stages stalls
// only when the stage after it is full and not draining.
// Stages: magnitude, leading-one alignment, rounding and packing.
// Reset: rst, synchronous, empties all stages; data registers are not reset.
module int32_to_float32_convert_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] int_value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [31:0] float_bits
);
  i2f_pkg::mag_t  mag_in, mag_q;
  i2f_pkg::norm_t norm_in, norm_q;
  logic [31:0]    flt_in;
  logic           v1, r1, v2, r2;

  assign mag_in.sign = s_tdata[31];
  assign mag_in.zero = (s_tdata == '0);
  assign mag_in.mag  = s_tdata[31] ? (32'd0 - s_tdata) : s_tdata;

  i2f_stage #(.Width($bits(i2f_pkg::mag_t))) u_s1 (
    .clk, .rst, .in_valid(s_tvalid), .in_ready(s_tready), .in_data(mag_in),
    .out_valid(v1), .out_ready(r1), .out_data(mag_q));

  i2f_norm u_norm (.m(mag_q), .n(norm_in));

  i2f_stage #(.Width($bits(i2f_pkg::norm_t))) u_s2 (
    .clk, .rst, .in_valid(v1), .in_ready(r1), .in_data(norm_in),
    .out_valid(v2), .out_ready(r2), .out_data(norm_q));

  i2f_round u_round (.n(norm_q), .f(flt_in));

  i2f_stage #(.Width(32)) u_s3 (
    .clk, .rst, .in_valid(v2), .in_ready(r2), .in_data(flt_in),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_data(m_tdata));

  a_norm_top: assert property (@(posedge clk) disable iff (rst)
    v2 && !norm_q.zero |-> norm_q.norm[31])
    else $error("normalized significand lacks leading one");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    v1 |-> (mag_q.zero == (mag_q.mag == '0)))
    else $error("zero flag disagrees with magnitude");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    v2 && !r2 |=> v2)
    else $error("stalled stage lost its word");
endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the int32 to float32 converter with random flow control.
module tb_top;
  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;

  logic [31:0] float_q[$];
  int unsigned err_cnt;
  int unsigned word_cnt;
  int unsigned burst_left;
  bit          stall_on;

  int32_to_float32_convert_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Round to nearest even from the bits below the 24-bit significand.
  function automatic logic [31:0] int_to_float(input logic [31:0] x);
    logic        sgn;
    logic [31:0] mag;
    logic [31:0] rem;
    logic [31:0] half;
    logic [24:0] sig;
    logic [7:0]  expo;
    int          pos;
    int          sh;
    if (x == '0) return '0;
    sgn = x[31];
    mag = sgn ? -x : x;
    pos = 0;
    for (int i = 0; i < 32; i++) if (mag[i]) pos = i;
    expo = 8'(pos + 127);
    if (pos <= 23) begin
      sig = 25'(mag << (23 - pos));
    end else begin
      sh   = pos - 23;
      rem  = mag & ((32'd1 << sh) - 32'd1);
      half = 32'd1 << (sh - 1);
      sig  = 25'(mag >> sh);
      if (rem > half || (rem == half && sig[0])) sig = sig + 25'd1;
      if (sig[24]) begin
        sig  = sig >> 1;
        expo = expo + 8'd1;
      end
    end
    return {sgn, expo, sig[22:0]};
  endfunction

  // Receiver: stall pattern that switches between stall-free and choppy stretches.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_on <= ~stall_on;
      m_tready <= stall_on ? ($urandom_range(0, 2) != 0) : 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (float_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected word %h", m_tdata);
      end else begin
        if (m_tdata !== float_q[0]) begin
          err_cnt++;
          if (err_cnt <= 10) $display("mismatch: expected %h actual %h", float_q[0], m_tdata);
        end
        void'(float_q.pop_front());
      end
    end
  end

  task automatic send_int(input logic [31:0] v);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 20);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    float_q.push_back(int_to_float(v));
    word_cnt++;
    burst_left--;
  endtask

  task automatic drain_all();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (float_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    logic [31:0] vals[$];
    vals = {32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
            32'h00FF_FFFF, 32'h0100_0000, 32'h0100_0001, 32'h0100_0003, 32'h0200_0002,
            32'h0200_0006, 32'h01FF_FFFF, 32'hFE00_0001, 32'h4000_0000, 32'h00AA_AAAA,
            32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFC0, 32'h7FFF_FF80, 32'h0000_0100};
    foreach (vals[i]) send_int(vals[i]);
  endtask

  task automatic test_random();
    logic [31:0] v;
    int          w;
    for (int n = 0; n < 1300; n++) begin
      w = $urandom_range(1, 32);
      v = $urandom;
      if (w < 32) v = v & ((32'd1 << w) - 32'd1);
      if ($urandom_range(0, 1)) v = -v;
      // hit exact ties and round carries in wide values
      if ($urandom_range(0, 7) == 0) v = {v[31:8], 8'h80};
      if ($urandom_range(0, 15) == 0) v = v | 32'h00FF_FFF0;
      send_int(v);
      if (n == 650) drain_all();
    end
  endtask

  initial begin
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    m_tready   = 1'b0;
    stall_on   = 1'b0;
    err_cnt    = 0;
    word_cnt   = 0;
    burst_left = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random();
    drain_all();
    repeat (10) @(posedge clk);
    $display("Converted %0d words: edge integers, rounding ties and carries, random widths.",
             word_cnt);
    if (err_cnt == 0 && float_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end
endmodule
